// ===== design/lpg_pkg.sv =====
package lpg_pkg;

    // panel and field sizes
    localparam int PANEL_SIZE  = 64;
    localparam int COORD_W     = 6;
    localparam int POS_W       = 7;
    localparam int ERR_W       = 9;
    localparam int COLOR_W     = 32;
    localparam int DIM_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    // input transfer packing, lowest bit first
    localparam int S_X0_LSB    = 0;
    localparam int S_Y0_LSB    = S_X0_LSB + COORD_W;
    localparam int S_X1_LSB    = S_Y0_LSB + COORD_W;
    localparam int S_Y1_LSB    = S_X1_LSB + COORD_W;
    localparam int S_COLOR_LSB = S_Y1_LSB + COORD_W;
    localparam int S_FIELDS_W  = S_COLOR_LSB + COLOR_W;
    localparam int S_DATA_W    = ((S_FIELDS_W + 7) / 8) * 8;

    // output transfer packing, lowest bit first
    localparam int M_FIELDS_W  = 2 * COORD_W + COLOR_W;
    localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_DATA_W - M_FIELDS_W;

    localparam logic [DIM_W-1:0] PANEL_DIM = DIM_W'(PANEL_SIZE);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic flush;
    } lpg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_free;
        logic pend_valid;
    } lpg_stat_t;

endpackage

// ===== design/lpg_ctrl.sv =====
module lpg_ctrl
    import lpg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  lpg_stat_t stat,
    output lpg_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (stat.walk_done) begin
                    state_next = ST_FLUSH;
                end else if (stat.out_free) begin
                    cmd.step = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!stat.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ===== design/lpg_datapath.sv =====
module lpg_datapath
    import lpg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  lpg_cmd_t            cmd,
    output lpg_stat_t           stat,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [DIM_W-1:0]    width_lim,
    input  logic [DIM_W-1:0]    height_lim,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    // captured line
    logic [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [COLOR_W-1:0] held_color_reg;

    // walk state
    logic [POS_W-1:0]        major_pos_reg, minor_pos_reg, major_end_reg;
    logic signed [ERR_W-1:0] error_term_reg;
    logic [COORD_W:0]        two_span_reg, two_mspan_reg;
    logic                    steep_flag_reg, minor_down_reg;

    // one-deep hold so the final pixel can be flagged
    logic               pend_valid_reg;
    logic [COORD_W-1:0] pend_x_reg, pend_y_reg;

    // output register
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;

    // setup arithmetic
    logic [COORD_W-1:0] adx, ady, a0, b0, a1, b1, sa0, sb0, sa1, sb1, span, mspan;
    logic               steep, swap;

    always_comb begin
        adx   = (x1_reg > x0_reg) ? (x1_reg - x0_reg) : (x0_reg - x1_reg);
        ady   = (y1_reg > y0_reg) ? (y1_reg - y0_reg) : (y0_reg - y1_reg);
        steep = (ady > adx);
        a0    = steep ? y0_reg : x0_reg;
        b0    = steep ? x0_reg : y0_reg;
        a1    = steep ? y1_reg : x1_reg;
        b1    = steep ? x1_reg : y1_reg;
        swap  = (a0 > a1);
        sa0   = swap ? a1 : a0;
        sb0   = swap ? b1 : b0;
        sa1   = swap ? a0 : a1;
        sb1   = swap ? b0 : b1;
        span  = sa1 - sa0;
        mspan = (sb1 > sb0) ? (sb1 - sb0) : (sb0 - sb1);
    end

    // step arithmetic
    logic [POS_W-1:0]        px, py;
    logic                    visible;
    logic signed [ERR_W-1:0] err_sub, err_add;

    always_comb begin
        px      = steep_flag_reg ? minor_pos_reg : major_pos_reg;
        py      = steep_flag_reg ? major_pos_reg : minor_pos_reg;
        visible = (px < width_lim) && (py < height_lim);
        err_sub = error_term_reg - $signed({2'b00, two_mspan_reg});
        err_add = err_sub + $signed({2'b00, two_span_reg});
    end

    logic out_free, out_load;
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = pend_valid_reg && ((cmd.step && visible) || cmd.flush);

    // line capture and walk registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x0_reg         <= s_tdata[S_X0_LSB +: COORD_W];
            y0_reg         <= s_tdata[S_Y0_LSB +: COORD_W];
            x1_reg         <= s_tdata[S_X1_LSB +: COORD_W];
            y1_reg         <= s_tdata[S_Y1_LSB +: COORD_W];
            held_color_reg <= s_tdata[S_COLOR_LSB +: COLOR_W];
        end
        if (cmd.setup) begin
            steep_flag_reg <= steep;
            minor_down_reg <= !(sb0 < sb1);
            major_pos_reg  <= {1'b0, sa0};
            minor_pos_reg  <= {1'b0, sb0};
            major_end_reg  <= {1'b0, sa1};
            error_term_reg <= $signed({3'b000, span});
            two_span_reg   <= {span, 1'b0};
            two_mspan_reg  <= {mspan, 1'b0};
        end else if (cmd.step) begin
            major_pos_reg <= major_pos_reg + POS_W'(1);
            if (err_sub[ERR_W-1]) begin
                minor_pos_reg  <= minor_down_reg ? (minor_pos_reg - POS_W'(1))
                                                 : (minor_pos_reg + POS_W'(1));
                error_term_reg <= err_add;
            end else begin
                error_term_reg <= err_sub;
            end
        end
    end

    // pending pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.step && visible) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.flush) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && visible) begin
            pend_x_reg <= px[COORD_W-1:0];
            pend_y_reg <= py[COORD_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_color_reg <= held_color_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_color_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

    assign stat.walk_done  = !(major_pos_reg < major_end_reg);
    assign stat.out_free   = out_free;
    assign stat.pend_valid = pend_valid_reg;

endmodule

// ===== design/line_pixel_generator.sv =====
// flow: a line transfer is captured, set up, then walked; each pixel is held in the pending
//   register until the next visible point is stepped, or flushed out as the last one
// throughput: the stepping loop walks one point per cycle while the output register is free;
//   a new line is accepted only in idle, after the previous line is walked and flushed
// reset: synchronous active-low aresetn clears the controller, the held pixel and the
//   output register; screen width and height return to 64
module line_pixel_generator
    import lpg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_x, start_y, end_x, end_y, line_color
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast
);

    logic [DIM_W-1:0] screen_width_reg, screen_height_reg;
    logic [DIM_W-1:0] width_lim, height_lim;
    lpg_cmd_t         cmd;
    lpg_stat_t        stat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= PANEL_DIM;
            screen_height_reg <= PANEL_DIM;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wr_data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // limit visible area to the panel
    assign width_lim  = (screen_width_reg > PANEL_DIM) ? PANEL_DIM : screen_width_reg;
    assign height_lim = (screen_height_reg > PANEL_DIM) ? PANEL_DIM : screen_height_reg;

    lpg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpg_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_tdata    (s_tdata),
        .width_lim  (width_lim),
        .height_lim (height_lim),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // no held pixel survives into idle
    assert property (@(posedge aclk) disable iff (!aresetn) s_tready |-> !stat.pend_valid)
        else $error("held pixel left over while idle");

    // after a line transfer is accepted, the input is not ready in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again during setup");

    // the datapath only moves a pixel out when the output register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step || cmd.flush) |-> stat.out_free)
        else $error("pixel issued into a busy output register");

endmodule
